/* design/assert_macros.svh */
// Assertion macros shared by the checker RTL.
// Simulation gets concurrent assertions; a SYNTH build gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed: lbl");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* design/kecc_pkg.sv */
// Types and constants for the key expression canonical-form checker.
// No dependencies.
`timescale 1ns / 1ps
package kecc_pkg;

    localparam int VERDICT_W       = 4;
    localparam int PREFIX_W        = 13;
    localparam int MAX_KEY_LEN_DEF = 4096;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    typedef enum logic [VERDICT_W-1:0] {
        V_OK               = 4'd0,
        V_EMPTY            = 4'd1,
        V_STAR_AFTER_DS    = 4'd2,
        V_DS_AFTER_DS      = 4'd3,
        V_LONE_DOLLAR_STAR = 4'd4,
        V_SHARP_QMARK      = 4'd5,
        V_DOLLAR_AFTER     = 4'd6,
        V_STARS            = 4'd7,
        V_UNBOUND          = 4'd8
    } t_verdict;

    // '$' binding tracker inside a chunk
    typedef enum logic [2:0] {
        PH_PLAIN  = 3'b001,
        PH_DOLLAR = 3'b010,
        PH_BOUND  = 3'b100
    } t_dphase;

    typedef struct packed {
        logic second_star;
        logic first_dollar;
        logic first_star;
    } t_head;

endpackage

/* design/kecc_in_if.sv */
// Input channel: one key byte per transfer plus last-byte flag.
// Depends on nothing but valid/ready handshake conventions.
`timescale 1ns / 1ps
interface kecc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       final_byte;

    modport source (output valid, output key_byte, output final_byte, input ready);
    modport sink   (input valid, input key_byte, input final_byte, output ready);
endinterface

/* design/kecc_out_if.sv */
// Result channel: verdict and canonical prefix length.
// Depends on kecc_pkg for field widths.
`timescale 1ns / 1ps
interface kecc_out_if;
    logic                           valid;
    logic                           ready;
    logic [kecc_pkg::VERDICT_W-1:0] verdict;
    logic [kecc_pkg::PREFIX_W-1:0]  canon_prefix_len;

    modport source (output valid, output verdict, output canon_prefix_len, input ready);
    modport sink   (input valid, input verdict, input canon_prefix_len, output ready);
endinterface

/* design/key_expression_canon_check.sv */
// Key expression canonical-form checker, one byte per transfer, one verdict per expression.
// Throughput: one byte per cycle; a closing byte stalls only while a result is still unread.
// The last byte passes the input register, then loads the result register.
// Reset: synchronous, active low; clears all scan state and both valid flags at once.
// Depends on kecc_pkg, kecc_in_if, kecc_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module key_expression_canon_check #(
    parameter int MAX_KEY_LEN = kecc_pkg::MAX_KEY_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kecc_in_if.sink           i_in,
    kecc_out_if.source        o_out
);
    import kecc_pkg::*;

    // Position counters saturate at MAX_KEY_LEN, so they must hold that value.
    localparam int POS_W = $clog2(MAX_KEY_LEN + 1);
    // Common width for the final truncation to the 13-bit output field.
    localparam int EXT_W = (POS_W > PREFIX_W) ? POS_W : PREFIX_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_KEY_LEN);

    // Per-expression scan state.
    typedef struct packed {
        logic [POS_W-1:0] byte_position;
        logic [POS_W-1:0] chunk_start_pos;
        logic [1:0]       chunk_len_sat;    // saturates at 3
        t_head            chunk_head;
        t_dphase          dollar_phase;
        t_verdict         pending_scan_error;
        logic             after_double_star;
        t_verdict         latched_verdict;
        logic [POS_W-1:0] latched_prefix;
    } t_state;

    localparam t_state ST_RESET = '{
        byte_position:      '0,
        chunk_start_pos:    '0,
        chunk_len_sat:      '0,
        chunk_head:         '0,
        dollar_phase:       PH_PLAIN,
        pending_scan_error: V_OK,
        after_double_star:  1'b0,
        latched_verdict:    V_OK,
        latched_prefix:     '0
    };

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v < POS_MAX) ? v + POS_W'(1) : POS_MAX;
    endfunction

    function automatic logic [POS_W-1:0] minus_three(input logic [POS_W-1:0] v);
        return (v >= POS_W'(3)) ? v - POS_W'(3) : '0;
    endfunction

    // Character rules, applied to every non-slash byte of a chunk.
    function automatic t_state scan_byte(input t_state s, input logic [7:0] b);
        t_state   r;
        t_verdict err;
        r   = s;
        err = V_OK;
        if (b == CH_HASH || b == CH_QMARK) begin
            err = V_SHARP_QMARK;
        end else if (b == CH_DOLLAR) begin
            if (s.dollar_phase != PH_PLAIN) err = V_DOLLAR_AFTER;
            else r.dollar_phase = PH_DOLLAR;
        end else if (b == CH_STAR) begin
            if (s.dollar_phase != PH_DOLLAR) err = V_STARS;
            else r.dollar_phase = PH_BOUND;
        end else begin
            if (s.dollar_phase == PH_DOLLAR) err = V_UNBOUND;
            else r.dollar_phase = PH_PLAIN;
        end
        if (err != V_OK && s.pending_scan_error == V_OK) r.pending_scan_error = err;
        return r;
    endfunction

    // Chunk-level rules, evaluated when a chunk closes.
    function automatic t_state end_chunk(input t_state s);
        t_state r;
        r = s;
        if (s.chunk_len_sat == 2'd0) begin
            r.latched_verdict = V_EMPTY;
        end else if (s.chunk_len_sat == 2'd1) begin
            // single character: only "*" after "**" is checked
            if (s.after_double_star && s.chunk_head.first_star) begin
                r.latched_verdict = V_STAR_AFTER_DS;
                r.latched_prefix  = minus_three(s.chunk_start_pos);
            end
        end else if (s.chunk_len_sat == 2'd2 && s.chunk_head.second_star &&
                     (s.chunk_head.first_dollar || s.chunk_head.first_star)) begin
            if (s.chunk_head.first_dollar) begin
                r.latched_verdict = V_LONE_DOLLAR_STAR;
                r.latched_prefix  = s.chunk_start_pos;
            end else if (s.after_double_star) begin
                r.latched_verdict = V_DS_AFTER_DS;
                r.latched_prefix  = minus_three(s.chunk_start_pos);
            end else begin
                r.after_double_star = 1'b1;
            end
        end else if (s.pending_scan_error != V_OK) begin
            r.latched_verdict = s.pending_scan_error;
        end else if (s.dollar_phase == PH_DOLLAR) begin
            r.latched_verdict = V_UNBOUND;
        end else begin
            r.after_double_star = 1'b0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input register stage
    // ---------------------------------------------------------------
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       s1_adv;
    logic       in_ready;

    // A non-last byte needs no result slot, so it always moves on.
    assign s1_adv   = r_s1_valid && (!r_s1_last || !o_out.valid || o_out.ready);
    assign in_ready = !r_s1_valid || s1_adv;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_byte <= i_in.key_byte;
            r_s1_last <= i_in.final_byte;
        end
    end

    // ---------------------------------------------------------------
    // Scan logic: byte in stage 1 against the stored state
    // ---------------------------------------------------------------
    t_state                r_st;
    t_state                n_st;
    t_state                step_st;     // state after this byte
    t_state                fin_st;      // state after closing the expression
    logic [EXT_W-1:0]      prefix_ext;
    t_verdict              n_out_verdict;
    logic [PREFIX_W-1:0]   n_out_prefix;

    always_comb begin
        step_st = r_st;
        if (r_st.latched_verdict == V_OK) begin
            if (r_s1_byte == CH_SLASH) begin
                step_st                    = end_chunk(r_st);
                step_st.chunk_start_pos    = sat_inc(r_st.byte_position);
                step_st.chunk_len_sat      = 2'd0;
                step_st.chunk_head         = '0;
                step_st.dollar_phase       = PH_PLAIN;
                step_st.pending_scan_error = V_OK;
            end else begin
                if (r_st.chunk_len_sat == 2'd0) begin
                    step_st.chunk_head.first_star   = (r_s1_byte == CH_STAR);
                    step_st.chunk_head.first_dollar = (r_s1_byte == CH_DOLLAR);
                end else if (r_st.chunk_len_sat == 2'd1 && r_s1_byte == CH_STAR) begin
                    step_st.chunk_head.second_star = 1'b1;
                end
                if (r_st.chunk_len_sat != 2'd3) begin
                    step_st.chunk_len_sat = r_st.chunk_len_sat + 2'd1;
                end
                step_st = scan_byte(step_st, r_s1_byte);
            end
        end
        step_st.byte_position = sat_inc(r_st.byte_position);

        // Closing the expression: a trailing slash is an empty last chunk.
        fin_st = step_st;
        if (step_st.latched_verdict == V_OK) begin
            if (r_s1_byte == CH_SLASH) fin_st.latched_verdict = V_EMPTY;
            else fin_st = end_chunk(step_st);
        end
        // Wildcard-fold verdicts keep their own prefix, others report full length.
        if (fin_st.latched_verdict != V_STAR_AFTER_DS &&
            fin_st.latched_verdict != V_DS_AFTER_DS &&
            fin_st.latched_verdict != V_LONE_DOLLAR_STAR) begin
            fin_st.latched_prefix = step_st.byte_position;
        end
        n_out_verdict = fin_st.latched_verdict;
        prefix_ext    = EXT_W'(fin_st.latched_prefix);
        n_out_prefix  = prefix_ext[PREFIX_W-1:0];

        // Last byte returns the scanner to its reset state for the next expression.
        n_st = r_s1_last ? ST_RESET : step_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (s1_adv) begin
            r_st <= n_st;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                r_out_valid;
    t_verdict            r_out_verdict;
    logic [PREFIX_W-1:0] r_out_prefix;
    logic                load_out;

    assign load_out = s1_adv && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_verdict <= n_out_verdict;
            r_out_prefix  <= n_out_prefix;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.verdict          = r_out_verdict;
    assign o_out.canon_prefix_len = r_out_prefix;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a closing byte leaving stage 1 always produces a pending result
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, load_out, r_out_valid)
    // the scanner is back at its reset state after each expression
    `ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, load_out,
                 r_st.byte_position == '0 && r_st.latched_verdict == V_OK)
    // a found verdict sticks until the expression ends
    `ASSERT_NEXT(a_verdict_sticky, i_clk, i_rst_n,
                 r_st.latched_verdict != V_OK && !load_out, $stable(r_st.latched_verdict))
    // a chunk never starts beyond the byte counter
    `ASSERT_IMPL(a_chunk_start_bound, i_clk, i_rst_n, 1'b1,
                 r_st.chunk_start_pos <= r_st.byte_position)

endmodule

/* sim/tb_top.sv */
// Self-checking bench for key_expression_canon_check: byte stream in, one verdict out.
// Depends on kecc_pkg, kecc_in_if, kecc_out_if and the checker RTL.
// Expected verdicts come from a behavioral canon-rule tracker kept in this file.
`timescale 1ns / 1ps
module tb_top;
    import kecc_pkg::*;

    localparam int CLK_HALF    = 2;       // 4 ns period
    localparam int RST_CYCLES  = 11;
    localparam int RANDOM_BYTES = 450;
    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SHOW_MAX    = 10;

    typedef struct {
        logic [7:0] key_byte;
        bit         last;
    } t_key_item;

    typedef struct {
        t_verdict              verdict;
        logic [PREFIX_W-1:0]   prefix;
    } t_canon_result;

    logic i_clk;
    logic i_rst_n;

    kecc_in_if  key_in ();
    kecc_out_if verdict_out ();

    key_expression_canon_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_in),
        .o_out   (verdict_out)
    );

    // ------------------------------------------------------------------
    // Clock, reset and cycle budget
    // ------------------------------------------------------------------
    int            cycle_cnt;
    t_canon_result expected_verdicts[$];

    initial begin
        i_rst_n                      = 1'b0;
        key_in.valid                 = 1'b0;
        key_in.key_byte              = 8'h00;
        key_in.final_byte            = 1'b0;
        verdict_out.ready            = 1'b0;
        i_clk                        = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop: a hung handshake or a lost result lands here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts still owed",
                     cycle_cnt, expected_verdicts.size());
            $display("status: fail");
            $finish;
        end
    end

    initial cycle_cnt = 0;

    // Gap length for either side. Mostly back to back or short,
    // now and then a long hole; a recurring calm window has no gaps.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_cnt % 1500) < 400) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // ------------------------------------------------------------------
    // Canon-rule tracker: mirrors the block's per-expression state.
    // ------------------------------------------------------------------
    logic [PREFIX_W-1:0] kx_pos;          // bytes seen, saturating
    logic [PREFIX_W-1:0] kx_chunk_start;  // first byte of the open chunk
    logic [1:0]          kx_chunk_len;    // chunk length, saturating at 3
    t_head               kx_head;         // what the first two bytes were
    t_dphase             kx_dollar;       // '$' binding inside the chunk
    t_verdict            kx_scan_err;     // first char-rule hit in this chunk
    bit                  kx_after_ds;     // last scanned-or-** chunk was "**"
    t_verdict            kx_verdict;      // first verdict, sticky
    logic [PREFIX_W-1:0] kx_prefix;

    function automatic logic [PREFIX_W-1:0] pos_next(input logic [PREFIX_W-1:0] v);
        return (v < MAX_KEY_LEN_DEF) ? v + 1'b1 : PREFIX_W'(MAX_KEY_LEN_DEF);
    endfunction

    function automatic logic [PREFIX_W-1:0] back_three(input logic [PREFIX_W-1:0] v);
        return (v >= PREFIX_W'(3)) ? v - PREFIX_W'(3) : '0;
    endfunction

    function void open_chunk();
        kx_chunk_len = 2'd0;
        kx_head      = '0;
        kx_dollar    = PH_PLAIN;
        kx_scan_err  = V_OK;
    endfunction

    function void clear_expression();
        kx_pos         = '0;
        kx_chunk_start = '0;
        open_chunk();
        kx_after_ds    = 1'b0;
        kx_verdict     = V_OK;
        kx_prefix      = '0;
    endfunction

    // Character rules: '#'/'?' never, '$' only to start "$*", '*' only right after '$'.
    function void scan_char(input logic [7:0] b);
        t_verdict err;
        err = V_OK;
        if (b == CH_HASH || b == CH_QMARK) begin
            err = V_SHARP_QMARK;
        end else if (b == CH_DOLLAR) begin
            if (kx_dollar != PH_PLAIN) err = V_DOLLAR_AFTER;
            else kx_dollar = PH_DOLLAR;
        end else if (b == CH_STAR) begin
            if (kx_dollar != PH_DOLLAR) err = V_STARS;
            else kx_dollar = PH_BOUND;
        end else begin
            if (kx_dollar == PH_DOLLAR) err = V_UNBOUND;
            else kx_dollar = PH_PLAIN;
        end
        if (err != V_OK && kx_scan_err == V_OK) kx_scan_err = err;
    endfunction

    // Judge the chunk that a '/' (or the end) just closed.
    function void close_chunk();
        if (kx_chunk_len == 2'd0) begin
            kx_verdict = V_EMPTY;
            return;
        end
        // one-char chunks skip the scan and leave the "**" flag alone
        if (kx_chunk_len == 2'd1) begin
            if (kx_after_ds && kx_head.first_star) begin
                kx_verdict = V_STAR_AFTER_DS;
                kx_prefix  = back_three(kx_chunk_start);
            end
            return;
        end
        if (kx_chunk_len == 2'd2 && kx_head.second_star) begin
            if (kx_head.first_dollar) begin
                kx_verdict = V_LONE_DOLLAR_STAR;
                kx_prefix  = kx_chunk_start;
                return;
            end
            if (kx_head.first_star) begin
                if (kx_after_ds) begin
                    kx_verdict = V_DS_AFTER_DS;
                    kx_prefix  = back_three(kx_chunk_start);
                end else begin
                    kx_after_ds = 1'b1;
                end
                return;
            end
        end
        if (kx_scan_err != V_OK) kx_verdict = kx_scan_err;
        else if (kx_dollar == PH_DOLLAR) kx_verdict = V_UNBOUND;
        else kx_after_ds = 1'b0;
    endfunction

    // Advance by one byte; returns 1 with the verdict when the byte ends the expression.
    function automatic bit canon_step(input logic [7:0] b, input bit last,
                                      output t_canon_result res);
        logic [PREFIX_W-1:0] p;
        p   = kx_pos;
        res = '{V_OK, '0};
        if (kx_verdict == V_OK) begin
            if (b == CH_SLASH) begin
                close_chunk();
                kx_chunk_start = pos_next(p);
                open_chunk();
            end else begin
                if (kx_chunk_len == 2'd0) begin
                    if (b == CH_STAR)   kx_head.first_star   = 1'b1;
                    if (b == CH_DOLLAR) kx_head.first_dollar = 1'b1;
                end else if (kx_chunk_len == 2'd1 && b == CH_STAR) begin
                    kx_head.second_star = 1'b1;
                end
                if (kx_chunk_len < 2'd3) kx_chunk_len = kx_chunk_len + 1'b1;
                scan_char(b);
            end
        end
        kx_pos = pos_next(p);
        if (!last) return 1'b0;
        // trailing '/' already closed its chunk above, the tail counts as empty
        if (kx_verdict == V_OK) begin
            if (b == CH_SLASH) kx_verdict = V_EMPTY;
            else close_chunk();
        end
        if (kx_verdict < V_STAR_AFTER_DS || kx_verdict > V_LONE_DOLLAR_STAR)
            kx_prefix = kx_pos;
        res.verdict = kx_verdict;
        res.prefix  = kx_prefix;
        clear_expression();
        return 1'b1;
    endfunction

    initial clear_expression();

    // ------------------------------------------------------------------
    // Stimulus build
    // ------------------------------------------------------------------
    t_key_item  key_items[$];      // bytes waiting for the driver
    logic [7:0] expr_buf[$];       // expression under construction
    int         total_bytes;
    int         total_exprs;
    string      word_pool = "abcdxyz019_-.";

    function void add_text(input string s);
        for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
    endfunction

    function void add_word(input int n);
        for (int i = 0; i < n; i++)
            expr_buf.push_back(word_pool[$urandom_range(0, word_pool.len() - 1)]);
    endfunction

    function automatic logic [7:0] bad_char();
        case ($urandom_range(0, 3))
            0:       return CH_HASH;
            1:       return CH_QMARK;
            2:       return CH_DOLLAR;
            default: return CH_STAR;
        endcase
    endfunction

    // Move the built expression to the driver queue, marking its last byte.
    function void flush_expr();
        t_key_item it;
        for (int i = 0; i < expr_buf.size(); i++) begin
            it.key_byte = expr_buf[i];
            it.last     = (i == expr_buf.size() - 1);
            key_items.push_back(it);
        end
        total_bytes += expr_buf.size();
        total_exprs++;
        expr_buf.delete();
    endfunction

    // Mostly well-formed chunks with random content, salted with broken ones and raw noise.
    function void random_expr();
        int n_chunks;
        int kind;
        n_chunks = $urandom_range(1, 5);
        for (int c = 0; c < n_chunks; c++) begin
            if (c > 0) expr_buf.push_back(CH_SLASH);
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                add_word($urandom_range(1, 4));
                if ($urandom_range(0, 5) == 0) begin
                    add_text("$*");
                    add_word($urandom_range(0, 2));
                end
            end else if (kind < 45) begin
                add_text("**");
            end else if (kind < 55) begin
                add_text("*");
            end else if (kind < 60) begin
                add_text("$*");
            end else if (kind < 67) begin
                add_word(1);
                add_text("$*");
            end else if (kind < 73) begin
                // empty chunk
            end else if (kind < 87) begin
                add_word($urandom_range(0, 2));
                expr_buf.push_back(bad_char());
                add_word($urandom_range(0, 2));
            end else begin
                repeat ($urandom_range(1, 3)) expr_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 19) == 0) expr_buf.push_back(CH_SLASH);
        if (expr_buf.size() == 0) expr_buf.push_back(CH_SLASH);
        flush_expr();
    endfunction

    initial begin
        total_bytes = 0;
        total_exprs = 0;
        // Directed: one case per verdict, single-char chunk, trailing slash,
        // and the byte extremes.
        add_text("a");      flush_expr();   // canonical one-char chunk
        add_text("/");      flush_expr();   // trailing slash, empty chunk
        add_text("**/*");   flush_expr();   // star after double star
        add_text("**/**");  flush_expr();   // double star after double star
        add_text("$*");     flush_expr();   // lone $*
        add_text("a#");     flush_expr();   // hash
        add_text("$$");     flush_expr();   // dollar after dollar
        add_text("a*");     flush_expr();   // stray star
        add_text("$a");     flush_expr();   // unbound dollar
        expr_buf.push_back(8'h00);
        expr_buf.push_back(8'hFF);
        flush_expr();
        while (total_bytes < RANDOM_BYTES) random_expr();
    end

    // ------------------------------------------------------------------
    // Input driver: changes at the falling edge, one item per transfer.
    // ------------------------------------------------------------------
    bit  in_taken;         // last rising edge moved a byte
    int  in_gap;
    int  out_stall;
    t_key_item next_item;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            key_in.valid <= 1'b0;
            in_gap       <= 0;
        end else if (!key_in.valid || in_taken) begin
            if (in_gap > 0) begin
                key_in.valid <= 1'b0;
                in_gap       <= in_gap - 1;
            end else if (key_items.size() > 0) begin
                next_item          = key_items.pop_front();
                key_in.valid      <= 1'b1;
                key_in.key_byte   <= next_item.key_byte;
                key_in.final_byte <= next_item.last;
                in_gap            <= pick_gap();
            end else begin
                key_in.valid <= 1'b0;
            end
        end
    end

    // Result side backpressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            verdict_out.ready <= 1'b0;
            out_stall         <= 0;
        end else if (out_stall > 0) begin
            verdict_out.ready <= 1'b0;
            out_stall         <= out_stall - 1;
        end else begin
            verdict_out.ready <= 1'b1;
            out_stall         <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge.
    // ------------------------------------------------------------------
    int            bytes_accepted;
    int            verdicts_checked;
    int            mismatches;
    bit [8:0]      verdict_kinds_seen;

    initial begin
        bytes_accepted     = 0;
        verdicts_checked   = 0;
        mismatches         = 0;
        verdict_kinds_seen = '0;
    end

    always @(posedge i_clk) begin : monitor
        t_canon_result want;
        t_canon_result fresh;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (verdict_out.valid && verdict_out.ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("unexpected verdict %0d prefix %0d at cycle %0d",
                                 verdict_out.verdict, verdict_out.canon_prefix_len,
                                 cycle_cnt);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (verdict_out.verdict <= V_UNBOUND)
                        verdict_kinds_seen[verdict_out.verdict] = 1'b1;
                    if (verdict_out.verdict !== want.verdict ||
                        verdict_out.canon_prefix_len !== want.prefix) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX)
                            $display("result %0d: verdict exp %0d got %0d, prefix exp %0d got %0d",
                                     verdicts_checked, want.verdict, verdict_out.verdict,
                                     want.prefix, verdict_out.canon_prefix_len);
                    end
                    verdicts_checked++;
                end
            end
            in_taken <= key_in.valid && key_in.ready;
            if (key_in.valid && key_in.ready) begin
                bytes_accepted++;
                if (canon_step(key_in.key_byte, key_in.final_byte, fresh))
                    expected_verdicts.push_back(fresh);
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        while (bytes_accepted < total_bytes || expected_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_verdicts.size() != 0) begin
            mismatches++;
            $display("%0d verdicts never arrived", expected_verdicts.size());
        end
        $display("ran %0d expressions (%0d bytes), %0d verdicts checked, %0d mismatches",
                 total_exprs, bytes_accepted, verdicts_checked, mismatches);
        $display("distinct verdict codes returned: %0d of 9", $countones(verdict_kinds_seen));
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
